@@ rtl/core/ocvg_pkg.sv @@
// ----------------------------------------------------------------------------
// ocvg_pkg: shared types, constants and the corner table for the cube vertex
// generator.
// ----------------------------------------------------------------------------
package ocvg_pkg;

	localparam int unsigned PosW   = 32;
	localparam int unsigned DirW   = 16;
	localparam int unsigned SideW  = 31;
	localparam int unsigned NumCorners = 8;
	localparam int unsigned CornerW = 3;
	// Normalize works on vectors whose components stay below 2^18 in magnitude.
	localparam int unsigned VecW   = 19;
	localparam int unsigned SumW   = 38;
	localparam int unsigned RadW   = 66;
	localparam int unsigned RootW  = 33;
	localparam int unsigned QuoW   = 20;
	localparam int unsigned DefDepth = 2;

	typedef logic signed [VecW-1:0] vec_c_t;

	typedef struct packed {
		logic signed [PosW-1:0] cx;
		logic signed [PosW-1:0] cy;
		logic signed [PosW-1:0] cz;
		logic signed [DirW-1:0] fx;
		logic signed [DirW-1:0] fy;
		logic signed [DirW-1:0] fz;
		logic [SideW-1:0]       side;
	} cube_t;

	typedef struct packed {
		logic signed [PosW-1:0] cx;
		logic signed [PosW-1:0] cy;
		logic signed [PosW-1:0] cz;
		logic signed [DirW-1:0] fx;
		logic signed [DirW-1:0] fy;
		logic signed [DirW-1:0] fz;
		logic [SideW-1:0]       side;
		logic signed [VecW-1:0] n1x;
		logic signed [VecW-1:0] n1y;
		logic signed [VecW-1:0] n2x;
		logic signed [VecW-1:0] n2y;
		logic signed [VecW-1:0] n2z;
		logic                   degen;
	} frame_t;

	typedef struct packed {
		logic signed [PosW-1:0] px;
		logic signed [PosW-1:0] py;
		logic signed [PosW-1:0] pz;
		logic [2:0]             color;
		logic [1:0]             tex;
		logic [CornerW-1:0]     idx;
		logic                   degen;
		logic                   last;
	} vert_t;

	function automatic logic [2:0] corner_color(input logic [CornerW-1:0] k);
		logic [2:0] c;
		case (k)
			3'd0: c = 3'd4;
			3'd1: c = 3'd2;
			3'd2: c = 3'd5;
			3'd3: c = 3'd6;
			3'd4: c = 3'd4;
			3'd5: c = 3'd2;
			3'd6: c = 3'd5;
			default: c = 3'd2;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] corner_tex(input logic [CornerW-1:0] k);
		logic [1:0] t;
		case (k[1:0])
			2'd0: t = 2'd3;
			2'd1: t = 2'd2;
			2'd2: t = 2'd0;
			default: t = 2'd1;
		endcase
		return t;
	endfunction

	// Sign bits, 1 meaning minus: {front, n1, n2}.
	function automatic logic [2:0] corner_neg(input logic [CornerW-1:0] k);
		logic [2:0] s;
		case (k[1:0])
			2'd0: s = 3'b000;
			2'd1: s = 3'b001;
			2'd2: s = 3'b011;
			default: s = 3'b010;
		endcase
		s[2] = k[2];
		return s;
	endfunction

endpackage

@@ rtl/core/ocvg_isqrt.sv @@
// ----------------------------------------------------------------------------
// ocvg_isqrt: pipelined integer square root
// Restoring square root, one result bit per stage, with stall on ce.
// Carries a side payload of width PW alongside.
// ----------------------------------------------------------------------------
module ocvg_isqrt
	import ocvg_pkg::*;
#(
	parameter int unsigned PW = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ce,
	input  logic             in_valid,
	input  logic [RadW-1:0]  radicand,
	input  logic [PW-1:0]    in_pay,
	output logic             out_valid,
	output logic [RootW-1:0] root,
	output logic [PW-1:0]    out_pay
);

	logic [RadW-1:0]  rem_s [RootW+1];
	logic [RootW-1:0] rt_s  [RootW+1];
	logic [RadW-1:0]  n_s   [RootW+1];
	logic [PW-1:0]    pay_s [RootW+1];
	logic             v_s   [RootW+1];

	assign rem_s[0] = '0;
	assign rt_s[0]  = '0;
	assign n_s[0]   = radicand;
	assign pay_s[0] = in_pay;
	assign v_s[0]   = in_valid;

	for (genvar g = 0; g < RootW; g++) begin : g_step
		logic [RadW+1:0] rem_c;
		logic [RadW+1:0] trial;
		logic            ge;
		assign rem_c = {rem_s[g], n_s[g][RadW-1 -: 2]};
		assign trial = {{(RadW-RootW){1'b0}}, rt_s[g], 2'b01};
		assign ge    = rem_c >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (ce) begin
				v_s[g+1] <= v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[g+1] <= ge ? RadW'(rem_c - trial) : RadW'(rem_c);
				rt_s[g+1]  <= {rt_s[g][RootW-2:0], ge};
				n_s[g+1]   <= {n_s[g][RadW-3:0], 2'b00};
				pay_s[g+1] <= pay_s[g];
			end
		end
	end

	assign out_valid = v_s[RootW];
	assign root      = rt_s[RootW];
	assign out_pay   = pay_s[RootW];

endmodule

@@ rtl/core/ocvg_rdiv.sv @@
// ----------------------------------------------------------------------------
// ocvg_rdiv: pipelined rounded division of v * 2^28 by s
// Restoring long division on magnitudes, one quotient bit per stage,
// then round half away from zero and restore the sign.
// ----------------------------------------------------------------------------
module ocvg_rdiv
	import ocvg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ce,
	input  logic             in_valid,
	input  logic [VecW-1:0]  num,
	input  logic [RootW-1:0] den,
	output logic             out_valid,
	output vec_c_t           quo
);

	// The magnitude of num * 2^28 / den is below 2^18; QuoW+1 bits with a
	// rounding bit cover it.
	localparam int unsigned Steps = QuoW + 1;
	localparam int unsigned NumW  = VecW - 1 + 28 + 1;

	logic [NumW-1:0]  rem_s [Steps+1];
	logic [Steps-1:0] q_s   [Steps+1];
	logic [RootW-1:0] d_s   [Steps+1];
	logic             neg_s [Steps+1];
	logic             v_s   [Steps+1];
	logic [VecW-2:0]  mag;

	assign mag = num[VecW-1] ? (VecW-1)'(-num) : num[VecW-2:0];
	// Numerator is mag * 2^29 so that one extra quotient bit gives the half.
	assign rem_s[0] = {mag, 29'd0};
	assign q_s[0]   = '0;
	assign d_s[0]   = den;
	assign neg_s[0] = num[VecW-1];
	assign v_s[0]   = in_valid;

	for (genvar g = 0; g < Steps; g++) begin : g_step
		localparam int unsigned Sh = Steps - 1 - g;
		logic [NumW+RootW-1:0] dsh;
		logic                  ge;
		assign dsh = {{NumW{1'b0}}, d_s[g]} << Sh;
		assign ge  = {{RootW{1'b0}}, rem_s[g]} >= dsh;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (ce) begin
				v_s[g+1] <= v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[g+1] <= ge ? NumW'({{RootW{1'b0}}, rem_s[g]} - dsh) : rem_s[g];
				q_s[g+1]   <= q_s[g] | (Steps'(ge) << Sh);
				d_s[g+1]   <= d_s[g];
				neg_s[g+1] <= neg_s[g];
			end
		end
	end

	logic [Steps-1:0] qr;
	assign qr        = Steps'((q_s[Steps] + Steps'(1)) >> 1);
	assign quo       = neg_s[Steps] ? VecW'(-qr) : VecW'(qr);
	assign out_valid = v_s[Steps];

endmodule

@@ rtl/core/ocvg_normal.sv @@
// ----------------------------------------------------------------------------
// ocvg_normal: normalize a three-component vector to Q2.14
// Sum of squares, pipelined square root, then three pipelined dividers.
// A zero vector gives zero components and a zero flag.
// ----------------------------------------------------------------------------
module ocvg_normal
	import ocvg_pkg::*;
#(
	parameter int unsigned PW = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           ce,
	input  logic           in_valid,
	input  vec_c_t         vx,
	input  vec_c_t         vy,
	input  vec_c_t         vz,
	input  logic [PW-1:0]  in_pay,
	output logic           out_valid,
	output vec_c_t         nx,
	output vec_c_t         ny,
	output vec_c_t         nz,
	output logic           zero,
	output logic [PW-1:0]  out_pay
);

	localparam int unsigned CW = PW + 3 * VecW;

	logic signed [2*VecW-1:0] sq_x_s1, sq_y_s1, sq_z_s1;
	logic [CW-1:0]            pay_s1;
	logic                     v_s1;
	logic [SumW-1:0]          sum_s2;
	logic [CW-1:0]            pay_s2;
	logic                     v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (ce) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			sq_x_s1 <= vx * vx;
			sq_y_s1 <= vy * vy;
			sq_z_s1 <= vz * vz;
			pay_s1  <= {in_pay, vx, vy, vz};
			sum_s2  <= SumW'(sq_x_s1) + SumW'(sq_y_s1) + SumW'(sq_z_s1);
			pay_s2  <= pay_s1;
		end
	end

	logic             sq_v;
	logic [RootW-1:0] root;
	logic [CW-1:0]    sq_pay;

	ocvg_isqrt #(.PW(CW)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (v_s2),
		.radicand  ({sum_s2, 28'd0}),
		.in_pay    (pay_s2),
		.out_valid (sq_v),
		.root      (root),
		.out_pay   (sq_pay)
	);

	// Zero radicand gives a zero root; divide by one then, the numerators are zero.
	logic [RootW-1:0] den;
	vec_c_t           ux, uy, uz;
	assign den = (root == '0) ? RootW'(1) : root;
	assign ux  = sq_pay[3*VecW-1 -: VecW];
	assign uy  = sq_pay[2*VecW-1 -: VecW];
	assign uz  = sq_pay[VecW-1:0];

	logic dv_x, dv_y, dv_z;
	ocvg_rdiv u_dx (.clk(clk), .arst_n(arst_n), .ce(ce), .in_valid(sq_v),
		.num(ux), .den(den), .out_valid(dv_x), .quo(nx));
	ocvg_rdiv u_dy (.clk(clk), .arst_n(arst_n), .ce(ce), .in_valid(sq_v),
		.num(uy), .den(den), .out_valid(dv_y), .quo(ny));
	ocvg_rdiv u_dz (.clk(clk), .arst_n(arst_n), .ce(ce), .in_valid(sq_v),
		.num(uz), .den(den), .out_valid(dv_z), .quo(nz));

	// Side data rides a delay line matched to the dividers.
	localparam int unsigned DivLat = QuoW + 1;
	logic [PW:0] dl_s [DivLat+1];
	assign dl_s[0] = {sq_pay[CW-1 -: PW], root == '0};
	for (genvar g = 0; g < DivLat; g++) begin : g_dl
		always_ff @(posedge clk) begin
			if (ce) begin
				dl_s[g+1] <= dl_s[g];
			end
		end
	end

	assign out_valid = dv_x;
	assign out_pay   = dl_s[DivLat][PW:1];
	assign zero      = dl_s[DivLat][0];

	property p_lanes;
		@(posedge clk) disable iff (!arst_n) (dv_x == dv_y) && (dv_y == dv_z);
	endproperty
	a_lanes: assert property (p_lanes) else $error("divider lanes out of step");

	property p_zero_out;
		@(posedge clk) disable iff (!arst_n)
			(out_valid && zero) |-> (nx == '0 && ny == '0 && nz == '0);
	endproperty
	a_zero_out: assert property (p_zero_out) else $error("zero vector gave nonzero normal");

	property p_v_chain;
		@(posedge clk) disable iff (!arst_n) (ce && in_valid) |=> v_s1;
	endproperty
	a_v_chain: assert property (p_v_chain) else $error("valid lost at entry");

endmodule

@@ rtl/core/ocvg_frame.sv @@
// ----------------------------------------------------------------------------
// ocvg_frame: build the cube's frame
// n1 from (fy, -fx, 0), then the rounded cross product front x n1 and n2.
// ----------------------------------------------------------------------------
module ocvg_frame
	import ocvg_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   ce,
	input  logic   in_valid,
	input  cube_t  cube,
	output logic   out_valid,
	output frame_t frame
);

	localparam int unsigned CubeW = $bits(cube_t);
	localparam int unsigned P2W   = CubeW + 2 * VecW + 1;

	logic          n1_v, n1_zero;
	vec_c_t        n1x, n1y, n1z;
	logic [CubeW-1:0] n1_pay;

	ocvg_normal #(.PW(CubeW)) u_n1 (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_valid(in_valid),
		.vx(VecW'(cube.fy)), .vy(VecW'(-VecW'(cube.fx))), .vz('0),
		.in_pay(cube), .out_valid(n1_v), .nx(n1x), .ny(n1y), .nz(n1z),
		.zero(n1_zero), .out_pay(n1_pay)
	);

	cube_t cb1;
	assign cb1 = cube_t'(n1_pay);

	// Cross product in Q4.28, n1z is always zero.
	localparam int unsigned PW2 = DirW + VecW;
	logic signed [PW2-1:0] a_s1, b_s1, c_s1, d_s1;
	logic                  v_s1;
	logic [P2W-1:0]        pay_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ce) begin
			v_s1 <= n1_v;
		end
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			a_s1   <= cb1.fz * n1y;
			b_s1   <= cb1.fz * n1x;
			c_s1   <= cb1.fx * n1y;
			d_s1   <= cb1.fy * n1x;
			pay_s1 <= {n1_pay, n1x, n1y, n1_zero};
		end
	end

	function automatic vec_c_t rnd14(input logic signed [PW2:0] x);
		logic [PW2:0] m;
		logic [PW2:0] r;
		m = x[PW2] ? (PW2+1)'(-x) : x;
		r = (m + (PW2+1)'(8192)) >> 14;
		return x[PW2] ? VecW'(-r) : VecW'(r);
	endfunction

	vec_c_t cx, cy, cz;
	assign cx = rnd14(-(PW2+1)'(a_s1));
	assign cy = rnd14((PW2+1)'(b_s1));
	assign cz = rnd14((PW2+1)'(c_s1) - (PW2+1)'(d_s1));

	logic           n2_v, n2_zero;
	vec_c_t         n2x, n2y, n2z;
	logic [P2W-1:0] n2_pay;
	ocvg_normal #(.PW(P2W)) u_n2 (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_valid(v_s1),
		.vx(cx), .vy(cy), .vz(cz), .in_pay(pay_s1),
		.out_valid(n2_v), .nx(n2x), .ny(n2y), .nz(n2z),
		.zero(n2_zero), .out_pay(n2_pay)
	);

	cube_t cb2;
	assign cb2 = cube_t'(n2_pay[P2W-1 -: CubeW]);

	always_comb begin
		frame.cx    = cb2.cx;
		frame.cy    = cb2.cy;
		frame.cz    = cb2.cz;
		frame.fx    = cb2.fx;
		frame.fy    = cb2.fy;
		frame.fz    = cb2.fz;
		frame.side  = cb2.side;
		frame.n1x   = n2_pay[2*VecW -: VecW];
		frame.n1y   = n2_pay[VecW:1];
		frame.n2x   = n2x;
		frame.n2y   = n2y;
		frame.n2z   = n2z;
		frame.degen = n2_pay[0];
	end
	assign out_valid = n2_v;

	property p_n1z;
		@(posedge clk) disable iff (!arst_n) n1_v |-> (n1z == '0);
	endproperty
	a_n1z: assert property (p_n1z) else $error("n1 has a z component");

	property p_n2_zero;
		@(posedge clk) disable iff (!arst_n)
			(n2_v && n2_zero) |-> (n2x == '0 && n2y == '0 && n2z == '0);
	endproperty
	a_n2_zero: assert property (p_n2_zero) else $error("n2 not cleared");

	property p_degen;
		@(posedge clk) disable iff (!arst_n)
			(out_valid && frame.degen) |-> (frame.fx == '0 && frame.fy == '0);
	endproperty
	a_degen: assert property (p_degen) else $error("degenerate flag without zero xy");

	property p_degen_n1;
		@(posedge clk) disable iff (!arst_n)
			(out_valid && frame.degen) |-> (frame.n1x == '0 && frame.n1y == '0);
	endproperty
	a_degen_n1: assert property (p_degen_n1) else $error("n1 not zero when degenerate");

endmodule

@@ rtl/core/ocvg_corner.sv @@
// ----------------------------------------------------------------------------
// ocvg_corner: corner sequencer and position pipeline
// Holds one frame, walks eight corners, and computes each position in three
// stages: direction sum, multiply, round and saturate.
// ----------------------------------------------------------------------------
module ocvg_corner
	import ocvg_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   ce,
	input  logic   in_valid,
	output logic   in_ready,
	input  frame_t frame,
	output logic   out_valid,
	output vert_t  vert
);

	localparam int unsigned DW = VecW + 2;
	localparam int unsigned MW = DW + SideW + 1;

	frame_t             fr_q;
	logic               busy_q;
	logic [CornerW-1:0] k_q;
	logic               fire;

	assign in_ready = !busy_q || (k_q == CornerW'(NumCorners - 1));
	assign fire     = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (ce) begin
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				busy_q <= k_q != CornerW'(NumCorners - 1);
				k_q    <= k_q + CornerW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce && in_valid && in_ready) begin
			fr_q <= frame;
		end
	end

	function automatic logic signed [DW-1:0] dsum(input logic signed [DirW-1:0] f,
		input vec_c_t a, input vec_c_t b, input logic [2:0] neg);
		logic signed [DW-1:0] t0, t1, t2;
		t0 = neg[2] ? -DW'(f) : DW'(f);
		t1 = neg[1] ? -DW'(a) : DW'(a);
		t2 = neg[0] ? -DW'(b) : DW'(b);
		return t0 + t1 + t2;
	endfunction

	logic [2:0] neg;
	assign neg = corner_neg(k_q);

	// Stage 1: direction sum.
	logic signed [DW-1:0]   dx_s1, dy_s1, dz_s1;
	logic signed [PosW-1:0] cx_s1, cy_s1, cz_s1;
	logic [SideW-1:0]       sd_s1;
	logic [CornerW-1:0]     k_s1;
	logic                   dg_s1, v_s1;
	// Stage 2: product.
	logic signed [MW-1:0]   mx_s2, my_s2, mz_s2;
	logic signed [PosW-1:0] cx_s2, cy_s2, cz_s2;
	logic [CornerW-1:0]     k_s2;
	logic                   dg_s2, v_s2;
	// Stage 3: rounded and saturated result.
	vert_t                  vt_s3;
	logic                   v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (ce) begin
			v_s1 <= fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	function automatic logic signed [PosW-1:0] place(input logic signed [PosW-1:0] c,
		input logic signed [MW-1:0] m);
		logic [MW-1:0]          mag;
		logic [MW-1:0]          r;
		logic signed [MW:0]     p;
		mag = m[MW-1] ? MW'(-m) : m;
		r   = (mag + MW'(16384)) >> 15;
		p   = (m[MW-1] ? -(MW+1)'(r) : (MW+1)'(r)) + (MW+1)'(c);
		if (p > (MW+1)'(2147483647)) begin
			return PosW'(2147483647);
		end else if (p < -(MW+1)'(33'sh80000000)) begin
			return {1'b1, {(PosW-1){1'b0}}};
		end
		return PosW'(p);
	endfunction

	always_ff @(posedge clk) begin
		if (ce) begin
			dx_s1 <= dsum(fr_q.fx, fr_q.n1x, fr_q.n2x, neg);
			dy_s1 <= dsum(fr_q.fy, fr_q.n1y, fr_q.n2y, neg);
			dz_s1 <= dsum(fr_q.fz, '0, fr_q.n2z, neg);
			cx_s1 <= fr_q.cx;
			cy_s1 <= fr_q.cy;
			cz_s1 <= fr_q.cz;
			sd_s1 <= fr_q.side;
			k_s1  <= k_q;
			dg_s1 <= fr_q.degen;

			mx_s2 <= MW'(dx_s1) * $signed({1'b0, sd_s1});
			my_s2 <= MW'(dy_s1) * $signed({1'b0, sd_s1});
			mz_s2 <= MW'(dz_s1) * $signed({1'b0, sd_s1});
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
			cz_s2 <= cz_s1;
			k_s2  <= k_s1;
			dg_s2 <= dg_s1;

			vt_s3.px    <= place(cx_s2, mx_s2);
			vt_s3.py    <= place(cy_s2, my_s2);
			vt_s3.pz    <= place(cz_s2, mz_s2);
			vt_s3.color <= corner_color(k_s2);
			vt_s3.tex   <= corner_tex(k_s2);
			vt_s3.idx   <= k_s2;
			vt_s3.degen <= dg_s2;
			vt_s3.last  <= k_s2 == CornerW'(NumCorners - 1);
		end
	end

	assign out_valid = v_s3;
	assign vert      = vt_s3;

	property p_last;
		@(posedge clk) disable iff (!arst_n)
			out_valid |-> (vert.last == (vert.idx == CornerW'(NumCorners - 1)));
	endproperty
	a_last: assert property (p_last) else $error("last flag off corner seven");

	property p_seq;
		@(posedge clk) disable iff (!arst_n)
			(ce && busy_q && k_q != CornerW'(NumCorners - 1)) |=> (busy_q && k_q != '0);
	endproperty
	a_seq: assert property (p_seq) else $error("corner run broken");

	property p_hold;
		@(posedge clk) disable iff (!arst_n) !ce |=> $stable(k_q);
	endproperty
	a_hold: assert property (p_hold) else $error("corner counter moved in stall");

endmodule

@@ rtl/core/oriented_cube_vertex_generator.sv @@
// ----------------------------------------------------------------------------
// oriented_cube_vertex_generator: eight cube corners per oriented cube
// Normalizes two frame vectors with pipelined square roots and dividers,
// then emits the eight corner positions through a three-stage pipeline.
//
// channel | dir | content
// s_axis  | in  | one cube: center, front, side length
// m_axis  | out | one corner, eight per cube, tlast on the eighth
//
// A new cube is taken only once the gap counter has run down; the corner
// sequencer emits one corner per cycle while ce is high. The depth lies mostly
// in the two 33-stage square roots and the two rows of three 21-stage dividers.
// Reset clears all valid bits and the sequencer. A stall at m_axis freezes the
// whole pipeline once more than SKID_DEPTH corners wait; an output queue of
// SKID_DEPTH + 4 entries (six by default) keeps the output side registered.
// ----------------------------------------------------------------------------
module oriented_cube_vertex_generator
	import ocvg_pkg::*;
#(
	parameter int unsigned SKID_DEPTH = DefDepth
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// center_x, center_y, center_z, front_x, front_y, front_z, side_length, pad
	input  logic [175:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// pos_x, pos_y, pos_z, color_bits, tex_corner, corner_index, degenerate, pad
	output logic [111:0] m_axis_tdata,
	output logic         m_axis_tlast
);

	localparam int unsigned CntW = $clog2(SKID_DEPTH + 1);

	// The pipeline runs while the output queue has room for everything in
	// the corner pipeline plus one.
	logic ce;
	logic [CntW-1:0] cnt_q;
	logic c_valid, c_ready, f_valid;
	cube_t  cube;
	frame_t frame;
	vert_t  vert;

	assign cube.cx   = s_axis_tdata[31:0];
	assign cube.cy   = s_axis_tdata[63:32];
	assign cube.cz   = s_axis_tdata[95:64];
	assign cube.fx   = s_axis_tdata[111:96];
	assign cube.fy   = s_axis_tdata[127:112];
	assign cube.fz   = s_axis_tdata[143:128];
	assign cube.side = s_axis_tdata[174:144];

	// Hold the frame stage output in a one-entry buffer between pipeline and
	// sequencer, so the frame pipeline advances freely under ce.
	frame_t hold_q;
	logic   hold_v_q;
	logic   seq_v;
	frame_t seq_f;
	assign seq_v = hold_v_q || f_valid;
	assign seq_f = hold_v_q ? hold_q : frame;

	// Only accept a new cube if the frame pipeline cannot pile up: the gap counter
	// gap_q holds s_axis_tready low after each accepted cube until it runs down.
	logic [2:0] gap_q;
	assign s_axis_tready = ce && (gap_q == '0);
	assign c_valid       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (ce) begin
			if (c_valid) begin
				gap_q <= 3'd7;
			end else if (gap_q != '0) begin
				gap_q <= gap_q - 3'd1;
			end
		end
	end

	ocvg_frame u_frame (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_valid(c_valid),
		.cube(cube), .out_valid(f_valid), .frame(frame)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
		end else if (ce) begin
			hold_v_q <= seq_v && !c_ready;
		end
	end
	always_ff @(posedge clk) begin
		if (ce && !(hold_v_q && !c_ready)) begin
			hold_q <= frame;
		end
	end

	logic v_valid;
	ocvg_corner u_corner (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_valid(seq_v), .in_ready(c_ready),
		.frame(seq_f), .out_valid(v_valid), .vert(vert)
	);

	// Output queue, SKID_DEPTH + 4 entries deep to absorb the corner pipeline.
	localparam int unsigned QD  = SKID_DEPTH + 4;
	localparam int unsigned QAW = $clog2(QD);
	localparam int unsigned QCW = $clog2(QD + 1);
	vert_t          q_mem [QD];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QCW-1:0] n_q;
	logic           push, pop;

	assign push = ce && v_valid;
	assign pop  = m_axis_tvalid && m_axis_tready;
	assign ce   = n_q <= QCW'(QD - 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			n_q   <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == QAW'(QD - 1)) ? '0 : wp_q + QAW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == QAW'(QD - 1)) ? '0 : rp_q + QAW'(1);
			end
			n_q   <= n_q + QCW'(push) - QCW'(pop);
			cnt_q <= (n_q > QCW'(SKID_DEPTH)) ? CntW'(SKID_DEPTH) : CntW'(n_q);
		end
	end
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wp_q] <= vert;
		end
	end

	vert_t hd;
	assign hd            = q_mem[rp_q];
	assign m_axis_tvalid = n_q != '0;
	assign m_axis_tlast  = hd.last;
	assign m_axis_tdata  = {7'd0, hd.degen, hd.idx, hd.tex, hd.color, hd.pz, hd.py, hd.px};

	property p_no_over;
		@(posedge clk) disable iff (!arst_n) n_q <= QCW'(QD);
	endproperty
	a_no_over: assert property (p_no_over) else $error("output queue overflow");

	property p_tlast_idx;
		@(posedge clk) disable iff (!arst_n)
			m_axis_tvalid |-> (m_axis_tlast == (hd.idx == CornerW'(NumCorners - 1)));
	endproperty
	a_tlast_idx: assert property (p_tlast_idx) else $error("tlast on wrong corner");

	property p_skid;
		@(posedge clk) disable iff (!arst_n) cnt_q <= CntW'(SKID_DEPTH);
	endproperty
	a_skid: assert property (p_skid) else $error("skid count out of range");

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the oriented cube vertex generator
// Sends cubes (center, front direction, side length) in random bursts, derives
// the eight expected corners of each accepted cube from its own fixed-point
// frame computation and compares every corner leaving the block, in order.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ocvg_pkg::*;

	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned NumRandom  = 255;
	localparam int unsigned Drain      = 300;

	typedef longint vec3_t [3];

	typedef struct {
		cube_t       cube;
		bit          typed;
		logic [95:0] pos_front;
		logic [95:0] pos_back;
	} stim_row_t;

	// Signs per corner, 1 meaning minus: front, first normal, second normal.
	localparam bit [2:0] CornerNeg [8] = '{3'b000, 3'b001, 3'b011, 3'b010,
		3'b100, 3'b101, 3'b111, 3'b110};
	localparam bit [2:0] CornerColor [8] = '{3'd4, 3'd2, 3'd5, 3'd6,
		3'd4, 3'd2, 3'd5, 3'd2};
	localparam bit [1:0] CornerTex [8] = '{2'd3, 2'd2, 2'd0, 2'd1,
		2'd3, 2'd2, 2'd0, 2'd1};

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// center_x, center_y, center_z, front_x, front_y, front_z, side_length, pad
	logic [175:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// pos_x, pos_y, pos_z, color_bits, tex_corner, corner_index, degenerate, pad
	logic [111:0] m_axis_tdata;
	logic         m_axis_tlast;

	logic [104:0] corners_due [$];
	int unsigned  fail_count = 0;
	int unsigned  corners_seen = 0;
	int unsigned  cubes_sent;
	int unsigned  degen_cubes;
	int unsigned  cycle_count = 0;
	bit           hold_output;
	bit           hold_done;

	oriented_cube_vertex_generator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint round_div(longint num, longint den);
		if (num >= 0)
			return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	function automatic longint floor_sqrt(longint unsigned n);
		longint unsigned root;
		longint unsigned bitpos;
		root = 0;
		bitpos = 64'd1 << 62;
		while (bitpos > n)
			bitpos >>= 2;
		while (bitpos != 0) begin
			if (n >= root + bitpos) begin
				n -= root + bitpos;
				root = (root >> 1) + bitpos;
			end else begin
				root >>= 1;
			end
			bitpos >>= 2;
		end
		return longint'(root);
	endfunction

	// Scales v to unit length in Q2.14; a zero vector stays zero.
	function automatic bit to_unit(input vec3_t v, output vec3_t u);
		longint unsigned mag2;
		longint root;
		mag2 = 0;
		for (int i = 0; i < 3; i++)
			mag2 += longint'(v[i] * v[i]);
		if (mag2 == 0) begin
			u = '{0, 0, 0};
			return 1'b0;
		end
		root = floor_sqrt(mag2 << 28);
		for (int i = 0; i < 3; i++)
			u[i] = round_div(v[i] * (64'sd1 << 28), root);
		return 1'b1;
	endfunction

	function automatic logic [104:0] pack_corner(logic [95:0] pos, int k, bit degen);
		return {degen, 3'(k), CornerTex[k], CornerColor[k], pos};
	endfunction

	// Queues the eight corners of one accepted cube.
	task automatic predict_corners(input stim_row_t row);
		vec3_t ctr, fr, v, n1, n2;
		longint half_side, d, p;
		bit degen;
		logic [95:0] pos;
		ctr = '{row.cube.cx, row.cube.cy, row.cube.cz};
		fr = '{row.cube.fx, row.cube.fy, row.cube.fz};
		half_side = longint'(row.cube.side);
		v = '{fr[1], -fr[0], 0};
		degen = !to_unit(v, n1);
		v[0] = round_div(fr[1] * n1[2] - fr[2] * n1[1], 16384);
		v[1] = round_div(fr[2] * n1[0] - fr[0] * n1[2], 16384);
		v[2] = round_div(fr[0] * n1[1] - fr[1] * n1[0], 16384);
		void'(to_unit(v, n2));
		if (degen)
			degen_cubes++;
		for (int k = 0; k < 8; k++) begin
			for (int i = 0; i < 3; i++) begin
				d = (CornerNeg[k][2] ? -fr[i] : fr[i]) + (CornerNeg[k][1] ? -n1[i] : n1[i])
					+ (CornerNeg[k][0] ? -n2[i] : n2[i]);
				p = ctr[i] + round_div(half_side * d, 32768);
				if (p > 64'sd2147483647)
					p = 64'sd2147483647;
				if (p < -64'sd2147483648)
					p = -64'sd2147483648;
				pos[i*32 +: 32] = p[31:0];
			end
			if (row.typed)
				pos = (k < 4) ? row.pos_front : row.pos_back;
			corners_due.push_back(pack_corner(pos, k, degen));
		end
	endtask

	function automatic stim_row_t mk(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
		logic [15:0] fx, logic [15:0] fy, logic [15:0] fz, logic [30:0] side);
		stim_row_t r;
		r.cube = '{cx: cx, cy: cy, cz: cz, fx: fx, fy: fy, fz: fz, side: side};
		r.typed = 1'b0;
		r.pos_front = '0;
		r.pos_back = '0;
		return r;
	endfunction

	// A front along z: the normals vanish, so every corner is center +- side/2 * front.
	function automatic stim_row_t mk_axis(logic [31:0] cz, logic [15:0] fz, logic [30:0] side,
		logic [31:0] zf, logic [31:0] zb);
		stim_row_t r;
		r = mk(32'd0, 32'd0, cz, 16'd0, 16'd0, fz, side);
		r.typed = 1'b1;
		r.pos_front = {zf, 32'd0, 32'd0};
		r.pos_back = {zb, 32'd0, 32'd0};
		return r;
	endfunction

	function automatic stim_row_t random_cube();
		stim_row_t r;
		int sel;
		int unit_sel;
		logic [15:0] a, b;
		sel = $urandom_range(0, 9);
		r = mk($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
			31'($urandom));
		if (sel < 6) begin
			// Well-formed cube: moderate center, near-unit front, small side.
			r.cube.cx = $signed($urandom_range(0, 2000000)) - 1000000;
			r.cube.cy = $signed($urandom_range(0, 2000000)) - 1000000;
			r.cube.cz = $signed($urandom_range(0, 2000000)) - 1000000;
			unit_sel = $urandom_range(0, 3);
			a = 16'($urandom_range(0, 16384));
			b = 16'(floor_sqrt(64'd268435456 - longint'(a) * a));
			r.cube.fx = $urandom_range(0, 1) ? -a : a;
			r.cube.fy = (unit_sel == 0) ? 16'd0 : ($urandom_range(0, 1) ? -b : b);
			r.cube.fz = (unit_sel == 0) ? ($urandom_range(0, 1) ? -b : b)
				: 16'($signed($urandom_range(0, 2000)) - 1000);
			r.cube.side = 31'($urandom_range(0, 20 << 16));
		end else if (sel == 6) begin
			r.cube.fx = 16'd0;
			r.cube.fy = 16'd0;
		end else if (sel == 7) begin
			r.cube.side = 31'(32'h7FFF_FFFF - $urandom_range(0, 3));
		end
		return r;
	endfunction

	// Output side: checks every accepted corner and sets the stall pattern.
	always @(posedge clk or negedge arst_n) begin
		logic [104:0] due;
		int stall_left;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_done <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				corners_seen++;
				if (corners_due.size() == 0) begin
					$display("%0t: unexpected corner %h", $time, m_axis_tdata);
					fail_count++;
				end else begin
					due = corners_due.pop_front();
					if (m_axis_tdata !== {7'd0, due} || m_axis_tlast !== (due[103:101] == 3'd7)) begin
						$display("%0t: corner mismatch: expected %h last %b, actual %h last %b",
							$time, {7'd0, due}, due[103:101] == 3'd7, m_axis_tdata, m_axis_tlast);
						fail_count++;
					end
				end
			end
			if (hold_output && !hold_done) begin
				m_axis_tready <= 1'b0;
				for (stall_left = 600; stall_left > 0; stall_left--)
					@(posedge clk);
				hold_done <= 1'b1;
			end else if ((cycle_count / 500) % 3 == 0) begin
				m_axis_tready <= 1'b1;
			end else if ((cycle_count / 500) % 3 == 1) begin
				m_axis_tready <= ($urandom_range(0, 3) != 0);
			end else begin
				m_axis_tready <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("%0t: timeout with %0d corners outstanding", $time, corners_due.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_cube(input stim_row_t row, inout int burst_left);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, row.cube.side, row.cube.fz, row.cube.fy, row.cube.fx,
			row.cube.cz, row.cube.cy, row.cube.cx};
		do @(posedge clk); while (!s_axis_tready);
		predict_corners(row);
		cubes_sent++;
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			burst_left = $urandom_range(0, 12);
		end else begin
			burst_left--;
		end
	endtask

	initial begin
		stim_row_t directed [$];
		int burst_left;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cubes_sent = 0;
		degen_cubes = 0;
		hold_output = 1'b0;
		burst_left = 4;

		directed = '{
			mk_axis(32'd0, 16'sd16384, 31'd131072, 32'd65536, -32'sd65536),
			mk_axis(32'd65536, -16'sd16384, 31'd65536, 32'd32768, 32'd98304),
			mk_axis(32'h7FFF_0000, 16'sd16384, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h3FFF_0000),
			mk_axis(32'h8000_0000, 16'sd16384, 31'h7FFF_FFFF, 32'hC000_0000, 32'h8000_0000),
			mk_axis(32'd12345, 16'sd16384, 31'd0, 32'd12345, 32'd12345),
			mk(32'd0, 32'd0, 32'd0, 16'sd16384, 16'd0, 16'd0, 31'd131072),
			mk(32'd0, 32'd0, 32'd0, 16'd0, 16'sd16384, 16'd0, 31'd131072),
			mk(32'd0, 32'd0, 32'd0, -16'sd16384, 16'd0, 16'd0, 31'd65536),
			mk(32'd0, 32'd0, 32'd0, 16'd11585, 16'd11585, 16'd0, 31'd65536),
			mk(32'd0, 32'd0, 32'd0, 16'd9459, -16'sd9459, 16'd9459, 31'd196608),
			mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd9459, 16'd9459, 16'd9459,
				31'h7FFF_FFFF),
			mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -16'sd9459, -16'sd9459,
				-16'sd9459, 31'h7FFF_FFFF),
			mk(32'd0, 32'd0, 32'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 31'h7FFF_FFFF),
			mk(32'd0, 32'd0, 32'd0, 16'h8000, 16'h8000, 16'h8000, 31'h7FFF_FFFF),
			mk(32'd5, 32'd7, 32'd9, 16'd1, 16'd0, 16'd0, 31'd65536),
			mk(32'd0, 32'd0, 32'd0, 16'd0, 16'd1, 16'h8000, 31'd65536),
			mk(32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 31'd65536),
			mk(32'hFFFF_FFFF, 32'd1, 32'hAAAA_5555, 16'h5555, 16'hAAAA, 16'd3, 31'h5555_AAAA)
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_cube(directed[i], burst_left);

		for (int n = 0; n < NumRandom; n++) begin
			if (n == 60) begin
				// Long output stall while cubes keep coming, so the input backs up.
				hold_output = 1'b1;
				burst_left = 40;
			end
			if (n == 160) begin
				s_axis_tvalid <= 1'b0;
				wait (corners_due.size() == 0);
				@(posedge clk);
			end
			send_cube(random_cube(), burst_left);
		end
		s_axis_tvalid <= 1'b0;

		wait (corners_due.size() == 0);
		repeat (Drain) @(posedge clk);

		$display("Sent %0d cubes (%0d with a front along z), checked %0d corners.",
			cubes_sent, degen_cubes, corners_seen);
		$display("Covered extreme centers and sides, saturation, odd fronts and a long stall.");
		if (fail_count == 0 && corners_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ oriented_cube_vertex_generator.f @@
rtl/core/ocvg_pkg.sv
rtl/core/ocvg_isqrt.sv
rtl/core/ocvg_rdiv.sv
rtl/core/ocvg_normal.sv
rtl/core/ocvg_frame.sv
rtl/core/ocvg_corner.sv
rtl/core/oriented_cube_vertex_generator.sv
tb/sv/testbench.sv
